>>> rtl/odo_pkg.sv
// Shared types, codes, constants and helper functions of the odometry block.
`default_nettype none
package odo_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int OFFSET_W = 19;
	localparam int WORD_W   = 32;
	localparam int SAT_W    = 68;
	localparam int ANGLE_W  = 35;
	localparam int ATAN_IDX_W = 5;

	localparam logic [1:0] OP_UPDATE    = 2'd0;
	localparam logic [1:0] OP_SET_CLEAR = 2'd1;
	localparam logic [1:0] OP_SET_ONLY  = 2'd2;

	localparam logic REG_FWD_OFFSET = 1'b0;
	localparam logic REG_LAT_OFFSET = 1'b1;

	localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
	localparam logic [33:0] PI_Q30      = 34'd3373259426;
	localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
	localparam logic [33:0] GAIN_Q30    = 34'd652032874;

	localparam logic [4:0] STEP_NONE  = 5'd0;
	localparam logic [4:0] STEP_DELTA = 5'd1;
	localparam logic [4:0] STEP_MULF  = 5'd2;
	localparam logic [4:0] STEP_MULL  = 5'd3;
	localparam logic [4:0] STEP_CORL  = 5'd4;
	localparam logic [4:0] STEP_MOD   = 5'd5;
	localparam logic [4:0] STEP_FOLD1 = 5'd6;
	localparam logic [4:0] STEP_FOLD2 = 5'd7;
	localparam logic [4:0] STEP_CORD  = 5'd8;
	localparam logic [4:0] STEP_FLIP  = 5'd9;
	localparam logic [4:0] STEP_ROT0  = 5'd10;
	localparam logic [4:0] STEP_ROT1  = 5'd11;
	localparam logic [4:0] STEP_ROT2  = 5'd12;
	localparam logic [4:0] STEP_ROT3  = 5'd13;
	localparam logic [4:0] STEP_ROT4  = 5'd14;
	localparam logic [4:0] STEP_ROT5  = 5'd15;
	localparam logic [4:0] STEP_POSE  = 5'd16;
	localparam logic [4:0] STEP_SETP  = 5'd17;
	localparam logic [4:0] STEP_PUB   = 5'd18;

	typedef struct packed {
		logic       capture;
		logic [4:0] step;
	} odo_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       mod_last;
		logic       cor_last;
	} odo_sts_t;

	function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(33'sh0_7FFF_FFFF);
		lo = SAT_W'(33'sh1_8000_0000);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[WORD_W-1:0];
	endfunction

	function automatic logic [29:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
		logic [29:0] r;
		unique case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/odo_ctrl.sv
// Controller state machine that sequences the odometry datapath.
`default_nettype none
module odo_ctrl
	import odo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire odo_sts_t sts,
	output odo_cmd_t      cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_DELTA = 5'd2;
	localparam logic [4:0] S_MULF  = 5'd3;
	localparam logic [4:0] S_MULL  = 5'd4;
	localparam logic [4:0] S_CORL  = 5'd5;
	localparam logic [4:0] S_MOD   = 5'd6;
	localparam logic [4:0] S_FOLD1 = 5'd7;
	localparam logic [4:0] S_FOLD2 = 5'd8;
	localparam logic [4:0] S_CORD  = 5'd9;
	localparam logic [4:0] S_FLIP  = 5'd10;
	localparam logic [4:0] S_ROT0  = 5'd11;
	localparam logic [4:0] S_ROT1  = 5'd12;
	localparam logic [4:0] S_ROT2  = 5'd13;
	localparam logic [4:0] S_ROT3  = 5'd14;
	localparam logic [4:0] S_ROT4  = 5'd15;
	localparam logic [4:0] S_ROT5  = 5'd16;
	localparam logic [4:0] S_POSE  = 5'd17;
	localparam logic [4:0] S_SETP  = 5'd18;
	localparam logic [4:0] S_DONE  = 5'd19;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic       out_valid_q;
	logic       publish;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign publish   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.step    = STEP_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_DISP;
			end
			S_DISP: begin
				if (sts.op == OP_UPDATE) begin
					state_d = S_DELTA;
				end else if (sts.op == OP_SET_CLEAR || sts.op == OP_SET_ONLY) begin
					state_d = S_SETP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DELTA: begin cmd.step = STEP_DELTA; state_d = S_MULF; end
			S_MULF:  begin cmd.step = STEP_MULF;  state_d = S_MULL; end
			S_MULL:  begin cmd.step = STEP_MULL;  state_d = S_CORL; end
			S_CORL:  begin cmd.step = STEP_CORL;  state_d = S_MOD;  end
			S_MOD: begin
				cmd.step = STEP_MOD;
				if (sts.mod_last) state_d = S_FOLD1;
			end
			S_FOLD1: begin cmd.step = STEP_FOLD1; state_d = S_FOLD2; end
			S_FOLD2: begin cmd.step = STEP_FOLD2; state_d = S_CORD;  end
			S_CORD: begin
				cmd.step = STEP_CORD;
				if (sts.cor_last) state_d = S_FLIP;
			end
			S_FLIP: begin cmd.step = STEP_FLIP; state_d = S_ROT0; end
			S_ROT0: begin cmd.step = STEP_ROT0; state_d = S_ROT1; end
			S_ROT1: begin cmd.step = STEP_ROT1; state_d = S_ROT2; end
			S_ROT2: begin cmd.step = STEP_ROT2; state_d = S_ROT3; end
			S_ROT3: begin cmd.step = STEP_ROT3; state_d = S_ROT4; end
			S_ROT4: begin cmd.step = STEP_ROT4; state_d = S_ROT5; end
			S_ROT5: begin cmd.step = STEP_ROT5; state_d = S_POSE; end
			S_POSE: begin cmd.step = STEP_POSE; state_d = S_DONE; end
			S_SETP: begin cmd.step = STEP_SETP; state_d = S_DONE; end
			S_DONE: begin
				if (publish) begin
					cmd.step = STEP_PUB;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_pub_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step == STEP_PUB) |-> (!out_valid_q || out_ready))
		else $error("result published over a pending transaction");
	a_capture_disp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == S_DISP))
		else $error("capture not followed by dispatch");
	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && sts.mod_last) |=> (state_q == S_FOLD1))
		else $error("angle reduction did not finish on its last step");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.capture)
		else $error("input captured while busy");

endmodule
`default_nettype wire

>>> rtl/odo_datapath.sv
// Datapath of the odometry block: pose state, angle reduction, CORDIC and multiplier.
`default_nettype none
module odo_datapath
	import odo_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_index,
	input  wire logic signed [OFFSET_W-1:0] cfg_data,
	input  wire odo_cmd_t                   cmd,
	output odo_sts_t                        sts,
	input  wire logic [1:0]                 op,
	input  wire logic signed [WORD_W-1:0]   forward_reading,
	input  wire logic signed [WORD_W-1:0]   lateral_reading,
	input  wire logic signed [WORD_W-1:0]   rotation_reading,
	input  wire logic signed [WORD_W-1:0]   new_x,
	input  wire logic signed [WORD_W-1:0]   new_y,
	input  wire logic signed [WORD_W-1:0]   new_heading,
	output logic signed [WORD_W-1:0]        pose_x,
	output logic signed [WORD_W-1:0]        pose_y,
	output logic signed [WORD_W-1:0]        pose_heading
);

	localparam int MidW       = 63 - FRAC_BITS;
	localparam int MagW       = MidW - 1;
	localparam int QuoW       = MagW - 32;
	localparam int MhW        = 26;
	localparam int RecipShift = 33;
	localparam int RecipW     = QuoW + 7;
	localparam int ModSteps   = 3;
	localparam int MaxSteps = (ModSteps > CORDIC_STEPS) ? ModSteps : CORDIC_STEPS;
	localparam int CntW     = $clog2(MaxSteps);
	localparam int ProdW    = WORD_W + ANGLE_W;
	localparam int DeltaW   = 38;

	// The quotient by 2*pi is estimated from the top bits of the magnitude and a reciprocal;
	// the estimate is low by at most one, so one compare and subtract finishes the remainder.
	localparam logic [RecipW-1:0] ModRecip =
		RecipW'((64'd1 << (QuoW + RecipShift + 6)) / 64'(TWO_PI_Q30));

	logic signed [OFFSET_W-1:0] fwd_off_q, lat_off_q;
	logic [1:0]                 op_q;
	logic signed [WORD_W-1:0]   rd_f_q, rd_l_q, rd_r_q, nx_q, ny_q, nh_q;
	logic signed [WORD_W-1:0]   last_f_q, last_l_q, last_r_q;
	logic signed [WORD_W-1:0]   x_q, y_q, heading_q;
	logic signed [WORD_W-1:0]   df_q, dl_q, dt_q, cf_q, cl_q;
	logic signed [WORD_W-1:0]   out_x_q, out_y_q, out_h_q;
	logic                       neg_q, flip_q;
	logic [MidW-2:0]            rem_q;
	logic [QuoW-1:0]            quo_q;
	logic [CntW-1:0]            cnt_q;
	logic signed [ANGLE_W-1:0]  z_q, cx_q, cy_q;
	logic signed [ProdW-1:0]    prod_q, acc_q;
	logic signed [DeltaW-1:0]   dx_q, dy_q;

	logic signed [WORD_W-1:0]   mul_a;
	logic signed [ANGLE_W-1:0]  mul_b;
	logic signed [MidW-1:0]     mid;
	logic [MidW-1:0]            mid_mag;
	logic [MhW+RecipW-1:0]      quo_prod;
	logic [MagW-1:0]            quo_twopi;
	logic signed [SAT_W-1:0]    off_round;
	logic signed [SAT_W-1:0]    acc_round;
	logic signed [ANGLE_W-1:0]  r0, r0_wrapped;
	logic signed [ANGLE_W-1:0]  xs, ys, at;

	assign sts.op       = op_q;
	assign sts.mod_last = (cnt_q == CntW'(ModSteps - 1));
	assign sts.cor_last = (cnt_q == CntW'(CORDIC_STEPS - 1));

	assign pose_x       = out_x_q;
	assign pose_y       = out_y_q;
	assign pose_heading = out_h_q;

	always_comb begin
		mid       = (MidW'(heading_q) <<< (30 - FRAC_BITS)) + (MidW'(dt_q) <<< (29 - FRAC_BITS));
		mid_mag   = mid[MidW-1] ? MidW'(-mid) : MidW'(mid);
		quo_prod  = (MhW+RecipW)'(rem_q[MagW-1:MagW-MhW]) * (MhW+RecipW)'(ModRecip);
		quo_twopi = MagW'(quo_q) * MagW'(TWO_PI_Q30);
		off_round = (SAT_W'(prod_q) + (SAT_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		acc_round = (SAT_W'(acc_q) + (SAT_W'(1) <<< 29)) >>> 30;
		r0 = (neg_q && rem_q[32:0] != 33'd0)
			? $signed(ANGLE_W'(TWO_PI_Q30) - ANGLE_W'(rem_q[32:0]))
			: $signed(ANGLE_W'(rem_q[32:0]));
		r0_wrapped = (r0 >= $signed(ANGLE_W'(PI_Q30))) ? r0 - $signed(ANGLE_W'(TWO_PI_Q30)) : r0;
		xs = cx_q >>> cnt_q;
		ys = cy_q >>> cnt_q;
		at = $signed(ANGLE_W'(atan_q30(ATAN_IDX_W'(cnt_q))));
		unique case (cmd.step)
			STEP_MULF: begin mul_a = dt_q; mul_b = ANGLE_W'(fwd_off_q); end
			STEP_MULL: begin mul_a = dt_q; mul_b = ANGLE_W'(lat_off_q); end
			STEP_ROT1: begin mul_a = cl_q; mul_b = cy_q; end
			STEP_ROT2: begin mul_a = cf_q; mul_b = cy_q; end
			STEP_ROT3: begin mul_a = cl_q; mul_b = cx_q; end
			default:   begin mul_a = cf_q; mul_b = cx_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.capture) begin
			op_q   <= op;
			rd_f_q <= forward_reading;
			rd_l_q <= lateral_reading;
			rd_r_q <= rotation_reading;
			nx_q   <= new_x;
			ny_q   <= new_y;
			nh_q   <= new_heading;
		end
		unique case (cmd.step)
			STEP_DELTA: begin
				df_q <= rd_f_q - last_f_q;
				dl_q <= rd_l_q - last_l_q;
				dt_q <= rd_r_q - last_r_q;
			end
			STEP_MULF: begin
				neg_q <= mid[MidW-1];
				rem_q <= mid_mag[MidW-2:0];
				cnt_q <= '0;
			end
			STEP_MULL: cf_q <= sat32(SAT_W'(df_q) - off_round);
			STEP_CORL: cl_q <= sat32(SAT_W'(dl_q) - off_round);
			STEP_MOD: begin
				if (cnt_q == '0) begin
					quo_q <= quo_prod[MhW+RecipW-1:RecipShift];
				end else if (cnt_q == CntW'(1)) begin
					rem_q <= rem_q - quo_twopi;
				end else if (rem_q >= MagW'(TWO_PI_Q30)) begin
					rem_q <= rem_q - MagW'(TWO_PI_Q30);
				end
				cnt_q <= cnt_q + 1'b1;
			end
			STEP_FOLD1: z_q <= r0_wrapped;
			STEP_FOLD2: begin
				if (z_q > $signed(ANGLE_W'(HALF_PI_Q30))) begin
					z_q    <= z_q - $signed(ANGLE_W'(PI_Q30));
					flip_q <= 1'b1;
				end else if (z_q < -$signed(ANGLE_W'(HALF_PI_Q30))) begin
					z_q    <= z_q + $signed(ANGLE_W'(PI_Q30));
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
				cx_q  <= $signed(ANGLE_W'(GAIN_Q30));
				cy_q  <= '0;
				cnt_q <= '0;
			end
			STEP_CORD: begin
				if (z_q >= 0) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - at;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + at;
				end
				cnt_q <= cnt_q + 1'b1;
			end
			STEP_FLIP: begin
				if (flip_q) begin
					cx_q <= -cx_q;
					cy_q <= -cy_q;
				end
			end
			STEP_ROT1: acc_q <= prod_q;
			STEP_ROT2: acc_q <= acc_q - prod_q;
			STEP_ROT3: begin
				dx_q  <= acc_round[DeltaW-1:0];
				acc_q <= prod_q;
			end
			STEP_ROT4: acc_q <= acc_q + prod_q;
			STEP_ROT5: dy_q <= acc_round[DeltaW-1:0];
			STEP_PUB: begin
				out_x_q <= x_q;
				out_y_q <= y_q;
				out_h_q <= heading_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_off_q <= '0;
			lat_off_q <= '0;
			last_f_q  <= '0;
			last_l_q  <= '0;
			last_r_q  <= '0;
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_FWD_OFFSET) fwd_off_q <= cfg_data;
				if (cfg_index == REG_LAT_OFFSET) lat_off_q <= cfg_data;
			end
			unique case (cmd.step)
				STEP_DELTA: begin
					last_f_q <= rd_f_q;
					last_l_q <= rd_l_q;
					last_r_q <= rd_r_q;
				end
				STEP_POSE: begin
					x_q       <= sat32(SAT_W'(x_q) + SAT_W'(dx_q));
					y_q       <= sat32(SAT_W'(y_q) + SAT_W'(dy_q));
					heading_q <= sat32(SAT_W'(heading_q) + SAT_W'(dt_q));
				end
				STEP_SETP: begin
					x_q       <= nx_q;
					y_q       <= ny_q;
					heading_q <= nh_q;
					if (op_q == OP_SET_CLEAR) begin
						last_f_q <= '0;
						last_l_q <= '0;
						last_r_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/perpendicular_wheel_odometry_top.sv
// Top level of the wheel and gyro odometry block: stream ports, controller and datapath.
// An update transaction runs the angle reduction and the CORDIC loop before it updates the
// pose; a set-pose transaction and an unused-op transaction skip both. One item is worked
// on at a time. The next input is taken the cycle after the result is published, while
// it waits in the output register. Reset clears the pose, the stored readings and both
// wheel offsets.
`default_nettype none
module perpendicular_wheel_odometry_top
	import odo_pkg::*;
#(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [OFFSET_W-1:0]  cfg_data,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	// forward_reading, lateral_reading, rotation_reading, new_x, new_y, new_heading.
	input  wire logic [191:0]         s_axis_tdata,
	// op.
	input  wire logic [1:0]           s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// pose_x, pose_y, pose_heading.
	output logic [95:0]               m_axis_tdata
);

	odo_cmd_t cmd;
	odo_sts_t sts;
	logic signed [WORD_W-1:0] pose_x, pose_y, pose_heading;

	odo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	odo_datapath #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         ($signed(cfg_data)),
		.cmd              (cmd),
		.sts              (sts),
		.op               (s_axis_tuser),
		.forward_reading  ($signed(s_axis_tdata[31:0])),
		.lateral_reading  ($signed(s_axis_tdata[63:32])),
		.rotation_reading ($signed(s_axis_tdata[95:64])),
		.new_x            ($signed(s_axis_tdata[127:96])),
		.new_y            ($signed(s_axis_tdata[159:128])),
		.new_heading      ($signed(s_axis_tdata[191:160])),
		.pose_x           (pose_x),
		.pose_y           (pose_y),
		.pose_heading     (pose_heading)
	);

	assign m_axis_tdata = {pose_heading, pose_y, pose_x};

endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for the wheel and gyro odometry block with its own pose predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	import odo_pkg::*;

	typedef struct {
		logic [1:0]         op;
		logic signed [31:0] fwd;
		logic signed [31:0] lat;
		logic signed [31:0] rot;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [31:0] nh;
	} odo_item_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] h;
	} pose_t;

	localparam int SENSOR_FRAC = 16;
	localparam int ROT_STEPS   = 16;
	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 20000;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam longint ANG_TWO_PI  = 64'sd6746518852;
	localparam longint ANG_PI      = 64'sd3373259426;
	localparam longint ANG_HALF_PI = 64'sd1686629713;
	localparam longint ANG_GAIN    = 64'sd652032874;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_index;
	logic [OFFSET_W-1:0] cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [191:0]        s_axis_tdata;
	logic [1:0]          s_axis_tuser;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [95:0]         m_axis_tdata;

	perpendicular_wheel_odometry_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	odo_item_t pending_items[$];
	pose_t     expected_poses[$];
	int        error_count;
	int        idle_cycles;
	int        send_gap;
	int        recv_gap;
	int        hold_off;
	int        offered_count;
	int        accepted_count;
	bit        long_hold_request;
	bit        item_busy;
	odo_item_t active_item;

	longint fwd_offset, lat_offset;
	logic [31:0] prev_fwd, prev_lat, prev_rot;
	logic signed [31:0] pose_x_q, pose_y_q, pose_h_q;

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_shr(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic longint arctan_entry(int i);
		longint t[24] = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
			16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071, 65535,
			32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
		return t[i];
	endfunction

	task automatic midpoint_sin_cos(input longint ang, output longint s, output longint c);
		longint r, vx, vy, t;
		bit flip;
		r = ang % ANG_TWO_PI;
		vx = ANG_GAIN;
		vy = 0;
		flip = 0;
		if (r < 0) r += ANG_TWO_PI;
		if (r >= ANG_PI) r -= ANG_TWO_PI;
		if (r > ANG_HALF_PI) begin
			r -= ANG_PI;
			flip = 1;
		end else if (r < -ANG_HALF_PI) begin
			r += ANG_PI;
			flip = 1;
		end
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (r >= 0) begin
				t = vx - floor_shr(vy, i);
				vy = vy + floor_shr(vx, i);
				r -= arctan_entry(i);
			end else begin
				t = vx + floor_shr(vy, i);
				vy = vy - floor_shr(vx, i);
				r += arctan_entry(i);
			end
			vx = t;
		end
		c = flip ? -vx : vx;
		s = flip ? -vy : vy;
	endtask

	task automatic track_pose(input odo_item_t it);
		longint df, dl, dt, cf, cl, mid, s, c, dx, dy;
		pose_t p;
		if (it.op == OP_UPDATE) begin
			df = $signed(it.fwd - prev_fwd);
			dl = $signed(it.lat - prev_lat);
			dt = $signed(it.rot - prev_rot);
			prev_fwd = it.fwd;
			prev_lat = it.lat;
			prev_rot = it.rot;
			cf = clamp32(df - round_shr(fwd_offset * dt, SENSOR_FRAC));
			cl = clamp32(dl - round_shr(lat_offset * dt, SENSOR_FRAC));
			mid = longint'(pose_h_q) * (64'sd1 <<< (30 - SENSOR_FRAC))
				+ dt * (64'sd1 <<< (29 - SENSOR_FRAC));
			midpoint_sin_cos(mid, s, c);
			dx = round_shr(cf * c - cl * s, 30);
			dy = round_shr(cf * s + cl * c, 30);
			pose_x_q = clamp32(longint'(pose_x_q) + dx);
			pose_y_q = clamp32(longint'(pose_y_q) + dy);
			pose_h_q = clamp32(longint'(pose_h_q) + dt);
		end else if (it.op == OP_SET_CLEAR || it.op == OP_SET_ONLY) begin
			pose_x_q = it.nx;
			pose_y_q = it.ny;
			pose_h_q = it.nh;
			if (it.op == OP_SET_CLEAR) begin
				prev_fwd = '0;
				prev_lat = '0;
				prev_rot = '0;
			end
		end
		p.x = pose_x_q;
		p.y = pose_y_q;
		p.h = pose_h_q;
		expected_poses.push_back(p);
	endtask

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Sender: one transaction per queued item, with a random gap after each.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
			item_busy     <= 1'b0;
			send_gap      <= 0;
			offered_count <= 0;
		end else if (item_busy && s_axis_tvalid && offered_count != accepted_count) begin
		end else if (send_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			item_busy     <= 1'b0;
			send_gap      <= send_gap - 1;
		end else if (pending_items.size() > 0) begin
			active_item = pending_items.pop_front();
			s_axis_tdata <= {active_item.nh, active_item.ny, active_item.nx,
				active_item.rot, active_item.lat, active_item.fwd};
			s_axis_tuser  <= active_item.op;
			s_axis_tvalid <= 1'b1;
			item_busy     <= 1'b1;
			offered_count <= offered_count + 1;
			send_gap      <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
		end else begin
			s_axis_tvalid <= 1'b0;
			item_busy     <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			accepted_count <= 0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			track_pose(active_item);
			accepted_count <= accepted_count + 1;
		end
	end

	// Receiver: random stalls plus one long hold-off on request.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
			hold_off      <= 0;
		end else if (long_hold_request && hold_off == 0) begin
			m_axis_tready <= 1'b0;
			hold_off      <= 600;
			long_hold_request = 1'b0;
		end else if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off      <= hold_off - 1;
		end else if (recv_gap > 0) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= recv_gap - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (m_axis_tvalid) begin
				recv_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// Monitor: compares each pose transaction with the oldest predicted pose.
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_poses.size() == 0) begin
				$error("pose transaction with no prediction waiting");
				error_count++;
			end else begin
				e = expected_poses.pop_front();
				if (m_axis_tdata[31:0] !== e.x) begin
					$error("pose_x expected %0d actual %0d", e.x, $signed(m_axis_tdata[31:0]));
					error_count++;
				end
				if (m_axis_tdata[63:32] !== e.y) begin
					$error("pose_y expected %0d actual %0d", e.y, $signed(m_axis_tdata[63:32]));
					error_count++;
				end
				if (m_axis_tdata[95:64] !== e.h) begin
					$error("pose_heading expected %0d actual %0d", e.h,
						$signed(m_axis_tdata[95:64]));
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** perpendicular_wheel_odometry_top: FAILED **");
				$finish;
			end
		end
	end

	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic odo_item_t make_item(logic [1:0] op, logic [31:0] f, logic [31:0] l,
			logic [31:0] r, logic [31:0] x, logic [31:0] y, logic [31:0] h);
		odo_item_t it;
		it.op = op; it.fwd = f; it.lat = l; it.rot = r;
		it.nx = x; it.ny = y; it.nh = h;
		return it;
	endfunction

	// Small steps along a smooth path, with an occasional wild jump.
	task automatic queue_drive_run(int count);
		logic [31:0] f, l, r;
		f = prev_fwd; l = prev_lat; r = prev_rot;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				f = any_word(); l = any_word(); r = any_word();
			end else begin
				f += 32'($signed($urandom_range(0, 262144)) - 131072);
				l += 32'($signed($urandom_range(0, 131072)) - 65536);
				r += 32'($signed($urandom_range(0, 65536)) - 32768);
			end
			pending_items.push_back(make_item(OP_UPDATE, f, l, r, $urandom, $urandom, $urandom));
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || item_busy || expected_poses.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_offset(logic idx, logic [OFFSET_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_FWD_OFFSET) fwd_offset = $signed(val);
		else lat_offset = $signed(val);
	endtask

	initial begin
		logic [OFFSET_W-1:0] offs[6];
		logic [1:0] op;
		error_count = 0;
		long_hold_request = 1'b0;
		fwd_offset = 0; lat_offset = 0;
		prev_fwd = '0; prev_lat = '0; prev_rot = '0;
		pose_x_q = '0; pose_y_q = '0; pose_h_q = '0;
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: offsets zero, then extremes of every field and op code.
		pending_items.push_back(make_item(OP_UPDATE, 32'h0001_0000, 0, 0, 0, 0, 0));
		pending_items.push_back(make_item(OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0003_243F, 0, 0, 0));
		pending_items.push_back(make_item(OP_UPDATE, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 0, 0, 0));
		pending_items.push_back(make_item(OP_SET_ONLY, 5, 6, 7, 32'h7FFF_FF00, 32'h8000_0100,
			32'h7FFF_FFFF));
		pending_items.push_back(make_item(OP_UPDATE, 32'h0FFF_FFFF, 32'hF000_0000,
			32'h7FFF_FFFF, 0, 0, 0));
		pending_items.push_back(make_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(OP_SET_CLEAR, 1, 2, 3, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000));
		pending_items.push_back(make_item(OP_UPDATE, 32'h0002_0000, 32'hFFFE_0000,
			32'hFFFC_DBC1, 0, 0, 0));
		pending_items.push_back(make_item(OP_SET_CLEAR, 0, 0, 0, 0, 0, 32'h0001_921F));
		pending_items.push_back(make_item(OP_UPDATE, 32'h0001_0000, 32'h0001_0000,
			32'h0000_8000, 0, 0, 0));
		wait_drained();

		offs = '{19'h20000, 19'h60000, 19'h00000, 19'h0FFFF, 19'h70000, 19'h10000};
		for (int phase = 0; phase < 6; phase++) begin
			write_offset(REG_FWD_OFFSET, offs[phase]);
			write_offset(REG_LAT_OFFSET, offs[(phase + 3) % 6]);
			if (phase >= 4) begin
				write_offset(REG_FWD_OFFSET, OFFSET_W'($urandom));
				write_offset(REG_LAT_OFFSET, OFFSET_W'($urandom));
			end
			for (int n = 0; n < 150; n++) begin
				op = $urandom_range(0, 19) == 0 ? 2'($urandom_range(1, 3)) : OP_UPDATE;
				if (op == OP_UPDATE) begin
					queue_drive_run(1);
				end else begin
					pending_items.push_back(make_item(op, any_word(), any_word(), any_word(),
						any_word(), any_word(), any_word()));
				end
			end
			if (phase == 2) begin
				long_hold_request = 1'b1;
			end
			wait_drained();
		end

		if (error_count == 0) begin
			$display("** perpendicular_wheel_odometry_top: PASSED **");
		end else begin
			$display("** perpendicular_wheel_odometry_top: FAILED **");
		end
		$finish;
	end

endmodule
`default_nettype wire
